// File: sv/error_host_blacklist_with_aging_unit_assert.svh
// Assertion macros shared by the blacklist RTL.
`ifndef ERROR_HOST_BLACKLIST_WITH_AGING_UNIT_ASSERT_SVH
`define ERROR_HOST_BLACKLIST_WITH_AGING_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define EHBL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define EHBL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EHBL_ASSERT(lbl, clk, rstn, prop, msg)
`define EHBL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: sv/ehbl_pkg.sv
`default_nettype none

package ehbl_pkg;

  localparam int unsigned TableEntriesDefault = 16;

  localparam int unsigned HostW  = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned ThrW   = 8;
  localparam int unsigned SumW   = 5;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 16;

  localparam logic [SumW-1:0]   SumMax   = '1;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    OP_RECORD  = 2'd0,
    OP_CHECK   = 2'd1,
    OP_REFRESH = 2'd2,
    OP_RESET   = 2'd3
  } op_e;

  localparam logic [CfgIdxW-1:0] CfgAvoidThreshold = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgForgiveSeconds = 1'b1;

  typedef struct packed {
    logic [HostW-1:0]  host;
    logic [CountW-1:0] count;
    logic [TimeW-1:0]  stamp;
  } entry_t;

endpackage

`default_nettype wire

// File: sv/ehbl_store.sv
`default_nettype none

module ehbl_store import ehbl_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDefault,
  localparam int unsigned IdxW = $clog2(TableEntries)
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [IdxW-1:0] waddr_i,
  input  wire entry_t          wdata_i,
  input  wire logic [IdxW-1:0] raddr_i,
  output      entry_t          rdata_o
);

  entry_t mem_q [TableEntries];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/error_host_blacklist_with_aging_unit.sv
// Channel   Direction  tdata (low bit up)                          tuser
// s_axis    in         host_id[15:0], now[47:16]                   op[1:0]
// m_axis    out        avoid, table_full, error_hosts[6:2],        -
//                      avoided_hosts[11:7], zero[15:12]
// cfg       in         index, 32-bit data, always ready            -
// Every op but reset sweeps the table through one read port, one entry per cycle,
// with one shared subtract and compare unit; a reset op skips the sweep.
// The last step waits while a previous result is not taken.
// Reset empties the table at once and clears both configuration registers.
`default_nettype none

`include "error_host_blacklist_with_aging_unit_assert.svh"

module error_host_blacklist_with_aging_unit import ehbl_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // host_id[15:0], now[47:16]
  input  wire logic [1:0]          s_axis_tuser,   // op[1:0]
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [OutDataW-1:0] m_axis_tdata,   // avoid, table_full, error_hosts,
                                                   // avoided_hosts, zero fill
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SWEEP  = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [IdxW-1:0] idx_q, idx_d, ev_idx_q, ev_idx_d;
  logic [IdxW-1:0] match_idx_q, match_idx_d, free_idx_q, free_idx_d;
  logic ev_q, ev_d, found_q, found_d, free_q, free_d;
  logic [SumW-1:0] nerr_q, nerr_d, navoid_q, navoid_d;
  logic [ThrW-1:0] thr_q;
  logic [TimeW-1:0] forgive_q;
  op_e op_q, op_d;
  logic [HostW-1:0] host_q, host_d;
  logic [TimeW-1:0] now_q, now_d;
  logic [CountW-1:0] match_cnt_q, match_cnt_d;
  logic out_vld_q, out_vld_d;
  logic out_avoid_q, out_avoid_d, out_full_q, out_full_d;
  logic [SumW-1:0] out_nerr_q, out_nerr_d, out_navoid_q, out_navoid_d;

  logic in_acc, finish_go, ent_valid, expire, cnt_reach;
  logic [TimeW:0] age;
  logic [CountW-1:0] thr_ext, cnt_inc;
  entry_t rd_ent, wr_ent;
  logic we;
  logic [IdxW-1:0] waddr;

  ehbl_store #(
    .TableEntries(TABLE_ENTRIES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wr_ent),
    .raddr_i(idx_q),
    .rdata_o(rd_ent)
  );

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign finish_go     = (state_q == ST_FINISH) && (!out_vld_q || m_axis_tready);

  // The shared unit: entry age against the forgive time.
  assign age       = {1'b0, now_q} - {1'b0, rd_ent.stamp};
  assign expire    = (forgive_q != '0) && !age[TimeW] && (age[TimeW-1:0] > forgive_q);
  assign thr_ext   = CountW'(thr_q);
  assign cnt_reach = rd_ent.count >= thr_ext;
  assign ent_valid = valid_q[ev_idx_q];
  assign cnt_inc   = (match_cnt_q == CountMax) ? match_cnt_q : match_cnt_q + 1'b1;

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    idx_d        = idx_q;
    ev_d         = ev_q;
    ev_idx_d     = ev_idx_q;
    found_d      = found_q;
    match_idx_d  = match_idx_q;
    match_cnt_d  = match_cnt_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    nerr_d       = nerr_q;
    navoid_d     = navoid_q;
    op_d         = op_q;
    host_d       = host_q;
    now_d        = now_q;
    out_vld_d    = out_vld_q && !m_axis_tready;
    out_avoid_d  = out_avoid_q;
    out_full_d   = out_full_q;
    out_nerr_d   = out_nerr_q;
    out_navoid_d = out_navoid_q;
    we           = 1'b0;
    waddr        = free_idx_q;
    wr_ent.host  = host_q;
    wr_ent.count = CountW'(1);
    wr_ent.stamp = now_q;

    if (ev_q) begin
      if ((op_q == OP_RECORD) || (op_q == OP_CHECK)) begin
        if (ent_valid && (rd_ent.host == host_q) && !found_q) begin
          found_d     = 1'b1;
          match_idx_d = ev_idx_q;
          match_cnt_d = rd_ent.count;
        end
        if (!ent_valid && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = ev_idx_q;
        end
      end else if (op_q == OP_REFRESH && ent_valid) begin
        if (expire) begin
          valid_d[ev_idx_q] = 1'b0;
        end else begin
          if (nerr_q != SumMax) begin
            nerr_d = nerr_q + 1'b1;
          end
          if ((thr_q != '0) && cnt_reach && (navoid_q != SumMax)) begin
            navoid_d = navoid_q + 1'b1;
          end
        end
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d     = op_e'(s_axis_tuser);
          host_d   = s_axis_tdata[HostW-1:0];
          now_d    = s_axis_tdata[HostW+TimeW-1:HostW];
          idx_d    = '0;
          ev_d     = 1'b0;
          found_d  = 1'b0;
          free_d   = 1'b0;
          nerr_d   = '0;
          navoid_d = '0;
          state_d  = (op_e'(s_axis_tuser) == OP_RESET) ? ST_FINISH : ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        ev_d     = 1'b1;
        ev_idx_d = idx_q;
        if (idx_q == LastIdx) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        ev_d    = 1'b0;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (finish_go) begin
          out_vld_d    = 1'b1;
          out_avoid_d  = 1'b0;
          out_full_d   = 1'b0;
          out_nerr_d   = '0;
          out_navoid_d = '0;
          state_d      = ST_IDLE;
          unique case (op_q)
            OP_RECORD: begin
              if (found_q) begin
                we           = 1'b1;
                waddr        = match_idx_q;
                wr_ent.count = cnt_inc;
                out_avoid_d  = cnt_inc >= thr_ext;
              end else if (free_q) begin
                we                  = 1'b1;
                valid_d[free_idx_q] = 1'b1;
              end else begin
                out_full_d = 1'b1;
              end
            end
            OP_CHECK: begin
              out_avoid_d = (thr_q != '0) && found_q && (match_cnt_q >= thr_ext);
            end
            OP_REFRESH: begin
              out_nerr_d   = nerr_q;
              out_navoid_d = navoid_q;
            end
            OP_RESET: begin
              valid_d = '0;
            end
            default: begin
              valid_d = valid_q;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      idx_q       <= '0;
      ev_q        <= 1'b0;
      ev_idx_q    <= '0;
      found_q     <= 1'b0;
      match_idx_q <= '0;
      free_q      <= 1'b0;
      free_idx_q  <= '0;
      nerr_q      <= '0;
      navoid_q    <= '0;
      op_q        <= OP_RECORD;
      out_vld_q   <= 1'b0;
      thr_q       <= '0;
      forgive_q   <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      idx_q       <= idx_d;
      ev_q        <= ev_d;
      ev_idx_q    <= ev_idx_d;
      found_q     <= found_d;
      match_idx_q <= match_idx_d;
      free_q      <= free_d;
      free_idx_q  <= free_idx_d;
      nerr_q      <= nerr_d;
      navoid_q    <= navoid_d;
      op_q        <= op_d;
      out_vld_q   <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgAvoidThreshold: thr_q     <= cfg_data_i[ThrW-1:0];
          CfgForgiveSeconds: forgive_q <= cfg_data_i[TimeW-1:0];
          default:           thr_q     <= thr_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    host_q       <= host_d;
    now_q        <= now_d;
    match_cnt_q  <= match_cnt_d;
    out_avoid_q  <= out_avoid_d;
    out_full_q   <= out_full_d;
    out_nerr_q   <= out_nerr_d;
    out_navoid_q <= out_navoid_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OutDataW - 2 - 2 * SumW)'(0), out_navoid_q, out_nerr_q,
                          out_full_q, out_avoid_q};

  `EHBL_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_acc |=> !s_axis_tready, "accepted while busy")
  `EHBL_ASSERT(a_avoided_le_hosts, clk_i, rst_ni, out_vld_q |-> (out_navoid_q <= out_nerr_q), "avoided count exceeds host count")
  `EHBL_ASSERT(a_full_excl_avoid, clk_i, rst_ni, out_vld_q |-> !(out_avoid_q && out_full_q), "avoid and table full together")
  `EHBL_ASSERT(a_full_means_full, clk_i, rst_ni, (finish_go && (op_q == OP_RECORD) && !found_q && !free_q) |-> (&valid_q), "table full reported with a free entry")

endmodule

`default_nettype wire

// File: test/error_host_blacklist_with_aging_unit_checker.sv
module error_host_blacklist_with_aging_unit_checker
  import ehbl_pkg::*;
#(
  parameter int unsigned ENTRIES = TableEntriesDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_i,
  input  wire logic [InDataW-1:0]  in_data_i,
  input  wire logic [1:0]          in_user_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_ready_i,
  input  wire logic [OutDataW-1:0] out_data_i,
  input  wire logic                cfg_valid_i,
  input  wire logic                cfg_ready_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned              failures_o,
  output int unsigned              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic            avoid;
    logic            table_full;
    logic [SumW-1:0] error_hosts;
    logic [SumW-1:0] avoided_hosts;
  } outcome_t;

  outcome_t          outcome_q [$];
  outcome_t          want;
  logic              slot_used  [ENTRIES];
  logic [HostW-1:0]  slot_host  [ENTRIES];
  logic [CountW-1:0] slot_count [ENTRIES];
  logic [TimeW-1:0]  slot_stamp [ENTRIES];
  logic [ThrW-1:0]   threshold;
  logic [TimeW-1:0]  forgive;
  int unsigned       fail_count;

  assign failures_o = fail_count;
  assign pending_o  = outcome_q.size();

  function automatic int lookup(input logic [HostW-1:0] host);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && slot_host[i] == host) return i;
    end
    return -1;
  endfunction

  function automatic outcome_t apply_op(input op_e op, input logic [HostW-1:0] host,
                                        input logic [TimeW-1:0] now);
    outcome_t res;
    int k;
    res = '0;
    case (op)
      OP_RECORD: begin
        k = lookup(host);
        if (k >= 0) begin
          if (slot_count[k] != CountMax) slot_count[k] = slot_count[k] + 1'b1;
          slot_stamp[k] = now;
          res.avoid = (slot_count[k] >= CountW'(threshold));
        end else begin
          for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!slot_used[i]) k = i;
          end
          if (k < 0) begin
            res.table_full = 1'b1;
          end else begin
            slot_used[k]  = 1'b1;
            slot_host[k]  = host;
            slot_count[k] = CountW'(1);
            slot_stamp[k] = now;
          end
        end
      end
      OP_CHECK: begin
        k = lookup(host);
        if (threshold != '0 && k >= 0) begin
          res.avoid = (slot_count[k] >= CountW'(threshold));
        end
      end
      OP_REFRESH: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i]) begin
            if (forgive != '0 && now > slot_stamp[i] && (now - slot_stamp[i]) > forgive) begin
              slot_used[i] = 1'b0;
            end else begin
              if (res.error_hosts != SumMax) res.error_hosts = res.error_hosts + 1'b1;
              if (threshold != '0 && slot_count[i] >= CountW'(threshold) &&
                  res.avoided_hosts != SumMax) begin
                res.avoided_hosts = res.avoided_hosts + 1'b1;
              end
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
      end
    endcase
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
    if (actual !== expected) begin
      fail_count++;
      if (fail_count <= 100) $error("%s: expected %0d, actual %0d", name, expected, actual);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outcome_q.delete();
      threshold = '0;
      forgive   = '0;
      for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
      fail_count = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgAvoidThreshold: threshold = cfg_data_i[ThrW-1:0];
          CfgForgiveSeconds: forgive   = cfg_data_i[TimeW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (outcome_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 100) $error("result transaction with no outstanding request");
        end else begin
          want = outcome_q.pop_front();
          compare_field("avoid", want.avoid, out_data_i[0]);
          compare_field("table_full", want.table_full, out_data_i[1]);
          compare_field("error_hosts", want.error_hosts, out_data_i[6:2]);
          compare_field("avoided_hosts", want.avoided_hosts, out_data_i[11:7]);
          compare_field("zero fill", '0, out_data_i[15:12]);
        end
      end
      if (in_valid_i && in_ready_i) begin
        outcome_q.insert(outcome_q.size(), apply_op(op_e'(in_user_i), in_data_i[HostW-1:0],
                                                    in_data_i[HostW +: TimeW]));
      end
    end
  end

endmodule

// File: test/error_host_blacklist_with_aging_unit_test.sv
module error_host_blacklist_with_aging_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ehbl_pkg::*;

  localparam int unsigned TableEntries = TableEntriesDefault;
  localparam int unsigned CycleLimit   = 6_000_000;
  localparam int unsigned SatRecords   = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  int unsigned failures;
  int unsigned pending;
  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned op_seen [4] = '{0, 0, 0, 0};
  int unsigned settings_done = 0;

  error_host_blacklist_with_aging_unit #(
    .TABLE_ENTRIES(TableEntries)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  error_host_blacklist_with_aging_unit_checker #(
    .ENTRIES(TableEntries)
  ) result_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .failures_o  (failures),
    .pending_o   (pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    wait (rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  task automatic set_regs(input logic [ThrW-1:0] thr, input logic [TimeW-1:0] fg);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgAvoidThreshold;
    cfg_data_i  <= CfgDataW'(thr);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CfgForgiveSeconds;
    cfg_data_i  <= fg;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    settings_done++;
  endtask

  task automatic send_op(input op_e op, input logic [HostW-1:0] host,
                         input logic [TimeW-1:0] now);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {now, host};
    do @(posedge clk_i); while (!s_axis_tready);
    op_seen[op]++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Well-formed traffic over a small host pool so that entries are hit repeatedly,
  // the table fills up and entries age out; time mostly moves forward.
  task automatic random_phase(input int n, input logic [ThrW-1:0] thr,
                              input logic [TimeW-1:0] fg, input bit long_hold);
    logic [HostW-1:0] pool [20];
    logic [HostW-1:0] host;
    logic [TimeW-1:0] now;
    int unsigned      pick;
    wait_idle();
    set_regs(thr, fg);
    if (long_hold) hold_req = 1'b1;
    foreach (pool[i]) pool[i] = HostW'($urandom());
    now = $urandom();
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) now = now - $urandom_range(0, 30);
      else now = now + $urandom_range(0, 8);
      if ($urandom_range(0, 7) == 0) host = HostW'($urandom());
      else host = pool[$urandom_range(0, 19)];
      pick = $urandom_range(0, 99);
      if (pick < 50) send_op(OP_RECORD, host, now);
      else if (pick < 75) send_op(OP_CHECK, host, now);
      else if (pick < 99) send_op(OP_REFRESH, host, now);
      else send_op(OP_RESET, host, now);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_regs(8'd0, 32'd0);
    send_op(OP_RECORD, 16'h0000, 32'd0);
    send_op(OP_RECORD, 16'h0000, 32'd5);
    send_op(OP_CHECK, 16'h0000, 32'd0);
    send_op(OP_CHECK, 16'hABCD, 32'd0);
    send_op(OP_RECORD, 16'hFFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < TableEntries - 2; i++) begin
      send_op(OP_RECORD, HostW'(16'h0100 + i), TimeW'(i));
    end
    send_op(OP_RECORD, 16'h7777, 32'd0);
    send_op(OP_REFRESH, 16'h0000, 32'hFFFF_FFFF);
    send_op(OP_RESET, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(OP_REFRESH, 16'h0000, 32'd0);

    wait_idle();
    set_regs(8'd2, 32'd10);
    send_op(OP_RECORD, 16'h1234, 32'd100);
    send_op(OP_RECORD, 16'h1234, 32'd105);
    send_op(OP_CHECK, 16'h1234, 32'd0);
    send_op(OP_RECORD, 16'h4321, 32'd50);
    send_op(OP_REFRESH, 16'h0000, 32'd40);
    send_op(OP_REFRESH, 16'h0000, 32'd115);
    send_op(OP_REFRESH, 16'h0000, 32'd116);

    // One host recorded well past the largest threshold.
    wait_idle();
    set_regs(8'd255, 32'd0);
    quiet = 1'b1;
    send_op(OP_RESET, 16'h0000, 32'd0);
    for (int i = 0; i < SatRecords; i++) send_op(OP_RECORD, 16'h5A5A, TimeW'(i));
    send_op(OP_CHECK, 16'h5A5A, 32'd0);
    send_op(OP_REFRESH, 16'h0000, 32'd0);
    quiet = 1'b0;

    random_phase(250, 8'd1, 32'd0, 1'b0);
    random_phase(250, 8'd3, 32'd20, 1'b1);
    random_phase(250, 8'd0, 32'd5, 1'b0);
    random_phase(250, 8'd2, 32'hFFFF_FFFF, 1'b0);
    random_phase(250, ThrW'($urandom_range(2, 6)), TimeW'($urandom_range(1, 40)), 1'b0);
    quiet = 1'b1;
    random_phase(250, 8'd4, 32'd1, 1'b0);

    wait_idle();
    repeat (4 * (TableEntries + 3)) @(posedge clk_i);
    $display("Covered %0d record, %0d check, %0d refresh and %0d reset transactions.",
             op_seen[OP_RECORD], op_seen[OP_CHECK], op_seen[OP_REFRESH], op_seen[OP_RESET]);
    $display("Used %0d register settings, thresholds 0 to 255, and one count past 255.",
             settings_done);
    if (failures == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
